@@ rtl/core/sal_pkg.sv @@
// Shared types, widths and codes for the shifting array list engine.
package sal_pkg;

  // Field widths of the request and response beats
  localparam int unsigned REQ_W        = 4;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned FOUND_W      = 6;
  localparam int unsigned TOTAL_W      = 6;

  localparam int unsigned CAPACITY_DEF = 32;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 4'd0;
  localparam logic [REQ_W-1:0] REQ_INS_BACK  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_INS_AT    = 4'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 4'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_BACK  = 4'd4;
  localparam logic [REQ_W-1:0] REQ_DEL_AT    = 4'd5;
  localparam logic [REQ_W-1:0] REQ_SEARCH    = 4'd6;
  localparam logic [REQ_W-1:0] REQ_AVERAGE   = 4'd7;
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 4'd8;

  // Response status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

  // Work class found by the decoder; OP_NONE means the response is already known
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_SEARCH,
    OP_AVERAGE
  } op_cls_e;

  // Kind of memory walk the datapath runs
  typedef enum logic [2:0] {
    WALK_NONE,
    WALK_UP,
    WALK_DN,
    WALK_SEARCH,
    WALK_SUM
  } walk_e;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_DECODE,
    CS_SHIFT_UP,
    CS_PUT,
    CS_SHIFT_DN,
    CS_SEARCH,
    CS_SUM,
    CS_DIV,
    CS_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic  load;
    logic  decode;
    walk_e walk;
    logic  put;
    logic  shrink;
    logic  div_start;
    logic  div_take;
    logic  emit;
  } sal_cmd_t;

  typedef struct packed {
    op_cls_e cls;
    logic    walk_done;
    logic    div_done;
    logic    out_free;
  } sal_sts_t;

endpackage

@@ rtl/core/sal_req_if.sv @@
// Request channel: valid/ready handshake with one list request per beat.
interface sal_req_if import sal_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

@@ rtl/core/sal_rsp_if.sv @@
// Response channel: valid/ready handshake with one result per beat.
interface sal_rsp_if import sal_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [FOUND_W-1:0]        found_position;
  logic signed [VALUE_W-1:0] average_value;
  logic [TOTAL_W-1:0]        entry_total;

  modport source (output valid, status, found_position, average_value, entry_total,
                  input ready);
  modport sink   (input valid, status, found_position, average_value, entry_total,
                  output ready);
endinterface

@@ rtl/core/sal_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
module sal_div import sal_pkg::*; #(
  parameter int unsigned NUM_W = VALUE_W + 6,
  parameter int unsigned DEN_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,   // held stable while busy
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DEN_W:0]    trial;
  logic              fits;

  always_comb begin
    trial  = {rem_q, quo_q[NUM_W-1]};
    fits   = (trial >= {1'b0, den_i});
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      step_d = STEP_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits DEN_W bits
      rem_d  = fits ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
      quo_d  = {quo_q[NUM_W-2:0], fits};
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ rtl/core/sal_dp.sv @@
// Datapath: element memory, count, walk pointer, sum, divider and output register.
module sal_dp import sal_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sal_cmd_t                  cmd_i,
  output sal_sts_t                  sts_o,
  input  logic [REQ_W-1:0]          req_type_i,
  input  logic [POS_W-1:0]          position_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic [FOUND_W-1:0]        found_position_o,
  output logic signed [VALUE_W-1:0] average_value_o,
  output logic [TOTAL_W-1:0]        entry_total_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = VALUE_W + CW;
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [PW-1:0] CAP_X = PW'(CAPACITY);

  // request latch
  logic [REQ_W-1:0]          req_q;
  logic [POS_W-1:0]          pos_q;
  logic signed [VALUE_W-1:0] val_q;

  // list state and walk
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             rem_q, rem_d;
  logic [AW-1:0]             ptr_q, ptr_d;
  logic [AW-1:0]             at_q, at_d;
  logic                      rd_en;
  logic                      rd_vld_q;
  logic [AW-1:0]             rd_tag_q;
  logic signed [VALUE_W-1:0] rd_data_q;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [VALUE_W-1:0]        wr_data;
  logic [VALUE_W-1:0]        mem_q [CAPACITY];

  // result build-up
  logic                      hit_q, hit_d;
  logic signed [SW-1:0]      sum_q, sum_d;
  logic [STATUS_W-1:0]       res_status_q, res_status_d;
  logic [CW-1:0]             res_found_q, res_found_d;
  logic signed [VALUE_W-1:0] res_avg_q, res_avg_d;

  // decode
  logic [PW-1:0]             pos_x, cnt_x, at_x;
  op_cls_e                   dec_cls;
  logic [STATUS_W-1:0]       dec_status;
  logic                      dec_clear;

  // divider
  logic [SW-1:0]             div_num;
  logic [SW-1:0]             div_quo;
  logic                      div_done;
  logic [VALUE_W-1:0]        quo_lo;

  // output register
  logic                      out_vld_q;
  logic [STATUS_W-1:0]       out_status_q;
  logic [FOUND_W-1:0]        out_found_q;
  logic signed [VALUE_W-1:0] out_avg_q;
  logic [TOTAL_W-1:0]        out_total_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
  end

  assign pos_x = PW'(pos_q);
  assign cnt_x = PW'(count_q);

  // classify the request and pick the gap position
  always_comb begin
    dec_cls    = OP_NONE;
    dec_status = STAT_OK;
    dec_clear  = 1'b0;
    unique case (req_q)
      REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
        if (req_q == REQ_INS_AT && (pos_x == '0 || pos_x > cnt_x + 1'b1)) begin
          dec_status = STAT_BADPOS;
        end else if (cnt_x >= CAP_X) begin
          dec_status = STAT_FULL;
        end else begin
          dec_cls = OP_INSERT;
        end
      end
      REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
        if (cnt_x == '0) begin
          dec_status = STAT_EMPTY;
        end else if (req_q == REQ_DEL_AT && (pos_x == '0 || pos_x > cnt_x)) begin
          dec_status = STAT_BADPOS;
        end else begin
          dec_cls = OP_DELETE;
        end
      end
      REQ_SEARCH: begin
        dec_status = STAT_NOTFOUND;
        dec_cls    = OP_SEARCH;
      end
      REQ_AVERAGE: begin
        if (cnt_x != '0) dec_cls = OP_AVERAGE;
      end
      REQ_CLEAR: begin
        dec_clear = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (req_q)
      REQ_INS_BACK:          at_x = cnt_x;
      REQ_DEL_BACK:          at_x = cnt_x - 1'b1;
      REQ_INS_AT, REQ_DEL_AT: at_x = pos_x - 1'b1;
      default:               at_x = '0;
    endcase
  end

  assign div_num = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign quo_lo  = div_quo[VALUE_W-1:0];

  always_comb begin
    count_d      = count_q;
    rem_d        = rem_q;
    ptr_d        = ptr_q;
    at_d         = at_q;
    hit_d        = hit_q;
    sum_d        = sum_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_avg_d    = res_avg_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = at_q;
    wr_data      = val_q;

    if (cmd_i.decode) begin
      res_status_d = dec_status;
      res_found_d  = '0;
      res_avg_d    = '0;
      hit_d        = 1'b0;
      sum_d        = '0;
      at_d         = AW'(at_x);
      if (dec_clear) count_d = '0;
      unique case (dec_cls)
        OP_INSERT: begin
          // move entries count-1 down to at one place up
          rem_d = CW'(cnt_x - at_x);
          ptr_d = AW'(cnt_x - 1'b1);
        end
        OP_DELETE: begin
          // move entries at+1 up to count-1 one place down
          rem_d = CW'(cnt_x - at_x - 1'b1);
          ptr_d = AW'(at_x + 1'b1);
        end
        default: begin
          rem_d = count_q;
          ptr_d = '0;
        end
      endcase
    end

    // issue one read per cycle
    if (cmd_i.walk != WALK_NONE && rem_q != '0) begin
      rd_en = 1'b1;
      rem_d = rem_q - 1'b1;
      ptr_d = (cmd_i.walk == WALK_UP) ? ptr_q - 1'b1 : ptr_q + 1'b1;
    end

    // consume the read issued last cycle
    if (rd_vld_q) begin
      unique case (cmd_i.walk)
        WALK_UP: begin
          wr_en   = 1'b1;
          wr_addr = rd_tag_q + 1'b1;
          wr_data = rd_data_q;
        end
        WALK_DN: begin
          wr_en   = 1'b1;
          wr_addr = rd_tag_q - 1'b1;
          wr_data = rd_data_q;
        end
        WALK_SEARCH: begin
          if (!hit_q && rd_data_q == val_q) begin
            hit_d        = 1'b1;
            rem_d        = '0;
            res_found_d  = CW'(rd_tag_q) + 1'b1;
            res_status_d = STAT_OK;
          end
        end
        WALK_SUM: begin
          sum_d = sum_q + SW'(rd_data_q);
        end
        default: ;
      endcase
    end

    if (cmd_i.put) begin
      wr_en   = 1'b1;
      wr_addr = at_q;
      wr_data = val_q;
      count_d = count_q + 1'b1;
    end

    if (cmd_i.shrink) count_d = count_q - 1'b1;

    if (cmd_i.div_take) begin
      res_avg_d = sum_q[SW-1] ? -$signed(quo_lo) : $signed(quo_lo);
    end
  end

  // element memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data_q <= mem_q[ptr_q];
      rd_tag_q  <= ptr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rem_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      count_q  <= count_d;
      rem_q    <= rem_d;
      rd_vld_q <= rd_en;
      hit_q    <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    at_q         <= at_d;
    sum_q        <= sum_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_avg_q    <= res_avg_d;
  end

  sal_div #(
    .NUM_W (SW),
    .DEN_W (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (count_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_found_q  <= FOUND_W'(res_found_q);
      out_avg_q    <= res_avg_q;
      out_total_q  <= TOTAL_W'(count_q);
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_found_q;
  assign average_value_o  = out_avg_q;
  assign entry_total_o    = out_total_q;

  assign sts_o.cls       = dec_cls;
  assign sts_o.walk_done = (rem_q == '0) && !rd_vld_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

endmodule

@@ rtl/core/sal_ctrl.sv @@
// Controller: sequences decode, memory walks, division and result hand-off.
module sal_ctrl import sal_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sal_sts_t sts_i,
  output sal_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE:     if (in_valid_i) state_d = CS_DECODE;
      CS_DECODE: begin
        unique case (sts_i.cls)
          OP_INSERT:  state_d = CS_SHIFT_UP;
          OP_DELETE:  state_d = CS_SHIFT_DN;
          OP_SEARCH:  state_d = CS_SEARCH;
          OP_AVERAGE: state_d = CS_SUM;
          default:    state_d = CS_DONE;
        endcase
      end
      CS_SHIFT_UP: if (sts_i.walk_done) state_d = CS_PUT;
      CS_PUT:      state_d = CS_DONE;
      CS_SHIFT_DN: if (sts_i.walk_done) state_d = CS_DONE;
      CS_SEARCH:   if (sts_i.walk_done) state_d = CS_DONE;
      CS_SUM:      if (sts_i.walk_done) state_d = CS_DIV;
      CS_DIV:      if (sts_i.div_done) state_d = CS_DONE;
      CS_DONE:     if (sts_i.out_free) state_d = CS_IDLE;
      default:     state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.walk      = WALK_NONE;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      CS_DECODE:   cmd_o.decode = 1'b1;
      CS_SHIFT_UP: cmd_o.walk   = WALK_UP;
      CS_PUT:      cmd_o.put    = 1'b1;
      CS_SHIFT_DN: begin
        cmd_o.walk   = WALK_DN;
        cmd_o.shrink = sts_i.walk_done;
      end
      CS_SEARCH:   cmd_o.walk = WALK_SEARCH;
      CS_SUM: begin
        cmd_o.walk      = WALK_SUM;
        cmd_o.div_start = sts_i.walk_done;
      end
      CS_DIV:      cmd_o.div_take = sts_i.div_done;
      CS_DONE:     cmd_o.emit     = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/shifting_array_list_engine_core.sv @@
// Top level of the shifting array list engine: controller plus datapath.
// One request at a time, n = entries held. Clear, rejects and an empty average go from decode
//   straight to the response; insert shifts n - at entries up, then writes the new value;
//   delete shifts n - at - 1 entries down; search reads entries up to the first hit;
//   average: one read per entry, one quotient bit per cycle.
// Next request is taken once the result is loaded; async reset empties the list, not memory.
module shifting_array_list_engine_core import sal_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sal_req_if.sink   req_i,
  sal_rsp_if.source rsp_o
);

  // command and status between the sequencer and the datapath
  sal_cmd_t cmd;
  sal_sts_t sts;
  logic     req_ready;

  // The controller owns the request side handshake; a request beat lands
  // while it sits idle, then it steps the datapath through the operation.
  sal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign req_i.ready = req_ready;

  // The datapath holds the list memory and count, runs pointer walks for
  // shifting, searching and summing, divides for the average, and owns the
  // response register that decouples the response side.
  sal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_i.req_type),
    .position_i       (req_i.position),
    .value_i          (req_i.value),
    .out_ready_i      (rsp_o.ready),
    .out_valid_o      (rsp_o.valid),
    .status_o         (rsp_o.status),
    .found_position_o (rsp_o.found_position),
    .average_value_o  (rsp_o.average_value),
    .entry_total_o    (rsp_o.entry_total)
  );

endmodule

@@ sim/shifting_array_list_engine_core_tb.sv @@
// Self-checking testbench for shifting_array_list_engine_core: directed table, then random traffic.
module shifting_array_list_engine_core_tb import sal_pkg::*; ();

  localparam int CAP            = CAPACITY_DEF;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int CALM_ITEMS     = 200;   // tail of the run with no idling
  localparam int PAUSE_EVERY    = 400;   // sender waits for a drained pipe this often
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either channel
  localparam int LINGER         = 120;   // longer than the slowest average request
  localparam int SHOWN_MAX      = 10;

  // Request codes the block has no use for
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 4'd9;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 4'd15;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [REQ_W-1:0]          op;
    logic [POS_W-1:0]          pos;
    logic signed [VALUE_W-1:0] val;
  } list_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [FOUND_W-1:0]        found;
    logic signed [VALUE_W-1:0] mean;
    logic [TOTAL_W-1:0]        total;
  } list_rsp_t;

  typedef struct {
    list_req_t req;
    bit        typed;   // rsp holds a hand-written answer
    list_rsp_t rsp;
  } stim_row_t;

  typedef enum int {EP_FILL, EP_DRAIN, EP_MIX} episode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  sal_req_if req_bus ();
  sal_rsp_if rsp_bus ();

  shifting_array_list_engine_core #(.CAPACITY(CAP)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #4 clk_i = ~clk_i;

  int        shadow_list [$];   // list contents as the block should hold them
  list_rsp_t expected_rsp [$];  // answers still owed by the block
  stim_row_t stim_table [$];
  int        mismatches  = 0;
  int        idle_cycles = 0;
  bit        typed_now   = 1'b0;
  list_rsp_t typed_rsp   = '0;
  bit        idle_on     = 1'b1;
  bit        calm        = 1'b0;

  // Applies one request to the shadow list and returns the answer it earns.
  function automatic list_rsp_t apply_request(list_req_t r);
    list_rsp_t o;
    int        n;
    int        at;
    longint    acc;
    o  = '0;
    n  = shadow_list.size();
    at = int'(r.pos) - 1;
    case (r.op)
      REQ_INS_FRONT: begin
        if (n < CAP) shadow_list.push_front(r.val);
        else o.status = STAT_FULL;
      end
      REQ_INS_BACK: begin
        if (n < CAP) shadow_list.push_back(r.val);
        else o.status = STAT_FULL;
      end
      REQ_INS_AT: begin
        // position is checked ahead of capacity
        if (r.pos < 1 || r.pos > n + 1) o.status = STAT_BADPOS;
        else if (n >= CAP) o.status = STAT_FULL;
        else if (at == n) shadow_list.push_back(r.val);
        else shadow_list.insert(at, r.val);
      end
      REQ_DEL_FRONT: begin
        if (n == 0) o.status = STAT_EMPTY;
        else void'(shadow_list.pop_front());
      end
      REQ_DEL_BACK: begin
        if (n == 0) o.status = STAT_EMPTY;
        else void'(shadow_list.pop_back());
      end
      REQ_DEL_AT: begin
        // empty list wins over a bad position
        if (n == 0) o.status = STAT_EMPTY;
        else if (r.pos < 1 || r.pos > n) o.status = STAT_BADPOS;
        else shadow_list.delete(at);
      end
      REQ_SEARCH: begin
        o.status = STAT_NOTFOUND;
        for (int i = 0; i < n && o.status != STAT_OK; i++) begin
          if (shadow_list[i] == r.val) begin
            o.found  = FOUND_W'(i + 1);
            o.status = STAT_OK;
          end
        end
      end
      REQ_AVERAGE: begin
        if (n > 0) begin
          acc = 0;
          for (int i = 0; i < n; i++) acc += shadow_list[i];
          acc    = acc / n;   // truncates toward zero
          o.mean = acc[VALUE_W-1:0];
        end
      end
      REQ_CLEAR: shadow_list.delete();
      default: ;
    endcase
    o.total = TOTAL_W'(shadow_list.size());
    return o;
  endfunction

  // Random request, weighted by episode; loud leans values to one extreme.
  function automatic list_req_t draw_request(episode_e ep, int loud);
    list_req_t r;
    int        n;
    int        roll;
    int        ins_w;
    int        del_w;
    int        lim;
    n     = shadow_list.size();
    ins_w = (ep == EP_FILL) ? 62 : (ep == EP_DRAIN) ? 14 : 32;
    del_w = (ep == EP_FILL) ? 12 : (ep == EP_DRAIN) ? 62 : 32;
    roll  = $urandom_range(0, 99);
    if (roll < ins_w) begin
      case ($urandom_range(0, 3))
        0: r.op = REQ_INS_FRONT;
        1: r.op = REQ_INS_BACK;
        default: r.op = REQ_INS_AT;
      endcase
    end else if (roll < ins_w + del_w) begin
      case ($urandom_range(0, 3))
        0: r.op = REQ_DEL_FRONT;
        1: r.op = REQ_DEL_BACK;
        default: r.op = REQ_DEL_AT;
      endcase
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 45) r.op = REQ_SEARCH;
      else if (roll < 85) r.op = REQ_AVERAGE;
      else if (roll < 93) r.op = (ep == EP_FILL) ? REQ_AVERAGE : REQ_CLEAR;
      else r.op = REQ_W'(REQ_SPARE_LO + $urandom_range(0, REQ_SPARE_HI - REQ_SPARE_LO));
    end

    // mostly legal positions, some at and just past the edges
    lim  = (r.op == REQ_DEL_AT) ? n : n + 1;
    roll = $urandom_range(0, 99);
    if (r.op != REQ_INS_AT && r.op != REQ_DEL_AT) r.pos = POS_W'($urandom_range(0, 255));
    else if (roll < 70) r.pos = POS_W'($urandom_range(1, (lim < 1) ? 1 : lim));
    else if (roll < 85) begin
      case ($urandom_range(0, 3))
        0: r.pos = '0;
        1: r.pos = POS_W'(lim);
        2: r.pos = POS_W'(lim + 1);
        default: r.pos = '1;
      endcase
    end else r.pos = POS_W'($urandom_range(0, 255));

    roll = $urandom_range(0, 99);
    if (r.op == REQ_SEARCH && n > 0 && roll < 50) r.val = shadow_list[$urandom_range(0, n - 1)];
    else if (loud != 0 && roll < 80) r.val = (loud == 1) ? VAL_MIN : VAL_MAX;
    else if (roll < 15) begin
      case ($urandom_range(0, 4))
        0: r.val = VAL_MIN;
        1: r.val = VAL_MAX;
        2: r.val = 0;
        3: r.val = -1;
        default: r.val = 1;
      endcase
    end else if (roll < 35) r.val = int'($urandom_range(0, 16)) - 8;   // repeats give search hits
    else r.val = $urandom;
    return r;
  endfunction

  task automatic add_row(logic [REQ_W-1:0] op, int pos, int val, bit typed,
                         logic [STATUS_W-1:0] st = STAT_OK, int found = 0, int total = 0);
    stim_row_t row;
    row.req.op       = op;
    row.req.pos      = POS_W'(pos);
    row.req.val      = val;
    row.typed        = typed;
    row.rsp.status   = st;
    row.rsp.found    = FOUND_W'(found);
    row.rsp.mean     = '0;
    row.rsp.total    = TOTAL_W'(total);
    stim_table.push_back(row);
  endtask

  task automatic note_mismatch(string what, list_rsp_t want, list_rsp_t got);
    mismatches++;
    if (mismatches <= SHOWN_MAX)
      $display("%0t %s: expected status=%0d found=%0d mean=%0d total=%0d",
               $time, what, want.status, want.found, want.mean, want.total,
               " | got status=%0d found=%0d mean=%0d total=%0d",
               got.status, got.found, got.mean, got.total);
  endtask

  // Moves to the next falling edge; unless calm, it sometimes then drops valid and idles.
  task automatic next_slot();
    @(negedge clk_i);
    if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
  endtask

  // Called just after a falling edge; returns at the edge that takes the beat.
  task automatic offer(list_req_t r, bit typed, list_rsp_t want);
    typed_now = typed;
    typed_rsp = want;
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= r.op;
    req_bus.position <= r.pos;
    req_bus.value    <= r.val;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Response side: ready comes in runs, some of them stalls.
  initial begin : sink_side
    int run;
    bit stall;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      run   = $urandom_range(1, 16);
      stall = idle_on && !calm && ($urandom_range(0, 2) == 0);
      @(negedge clk_i);
      rsp_bus.ready <= !stall;
      repeat (run - 1) @(negedge clk_i);
    end
  end

  // Both channels are sampled here; an accepted request is predicted on the spot.
  always @(posedge clk_i) begin : monitor
    list_rsp_t got;
    list_rsp_t want;
    list_req_t seen;
    bit        moved;
    if (rst_ni === 1'b1) begin
      moved = 1'b0;
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
        moved      = 1'b1;
        got.status = rsp_bus.status;
        got.found  = rsp_bus.found_position;
        got.mean   = rsp_bus.average_value;
        got.total  = rsp_bus.entry_total;
        if (expected_rsp.size() == 0) note_mismatch("result with nothing pending", '0, got);
        else begin
          want = expected_rsp.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.mean !== want.mean || got.total !== want.total)
            note_mismatch("result differs", want, got);
        end
      end
      if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
        moved    = 1'b1;
        seen.op  = req_bus.req_type;
        seen.pos = req_bus.position;
        seen.val = req_bus.value;
        want     = apply_request(seen);
        if (typed_now) want = typed_rsp;
        expected_rsp.push_back(want);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("shifting_array_list_engine_core_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    list_req_t r;
    episode_e  ep;
    int        loud;
    int        span;
    int        counted;
    int        next_pause;
    rst_ni           = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_INS_FRONT;
    req_bus.position = '0;
    req_bus.value    = '0;

    // Empty list: every delete and search refused, average is zero, bad insert positions refused
    add_row(REQ_AVERAGE,   0, 0, 1'b1, STAT_OK, 0, 0);
    add_row(REQ_DEL_FRONT, 0, 0, 1'b1, STAT_EMPTY, 0, 0);
    add_row(REQ_DEL_BACK,  0, 0, 1'b1, STAT_EMPTY, 0, 0);
    add_row(REQ_DEL_AT,    0, 0, 1'b1, STAT_EMPTY, 0, 0);
    add_row(REQ_SEARCH,    0, 0, 1'b1, STAT_NOTFOUND, 0, 0);
    add_row(REQ_INS_AT,    0, 1, 1'b1, STAT_BADPOS, 0, 0);
    add_row(REQ_INS_AT,    2, 1, 1'b1, STAT_BADPOS, 0, 0);
    // Build MIN, MAX, -1, 5, then search it and average it
    add_row(REQ_INS_AT,    1, VAL_MAX, 1'b1, STAT_OK, 0, 1);
    add_row(REQ_INS_FRONT, 0, VAL_MIN, 1'b1, STAT_OK, 0, 2);
    add_row(REQ_INS_BACK,  0, -1,      1'b1, STAT_OK, 0, 3);
    add_row(REQ_INS_AT,    4, 5,       1'b1, STAT_OK, 0, 4);
    add_row(REQ_SEARCH,    0, 5,       1'b1, STAT_OK, 4, 4);
    add_row(REQ_SEARCH,    0, VAL_MIN, 1'b1, STAT_OK, 1, 4);
    add_row(REQ_SEARCH,    0, 6,       1'b1, STAT_NOTFOUND, 0, 4);
    add_row(REQ_AVERAGE,   0, 0,       1'b0);
    // Positions past the end
    add_row(REQ_DEL_AT,    5,   0,  1'b1, STAT_BADPOS, 0, 4);
    add_row(REQ_DEL_AT,    255, 0,  1'b1, STAT_BADPOS, 0, 4);
    add_row(REQ_INS_AT,    255, 7,  1'b1, STAT_BADPOS, 0, 4);
    // Unused codes leave the list alone; then delete down to -1
    add_row(REQ_SPARE_HI,  255, -1, 1'b1, STAT_OK, 0, 4);
    add_row(REQ_SPARE_LO,  0,   0,  1'b1, STAT_OK, 0, 4);
    add_row(REQ_DEL_AT,    2,   0,  1'b0);
    add_row(REQ_DEL_FRONT, 0,   0,  1'b0);
    add_row(REQ_DEL_BACK,  0,   0,  1'b0);
    // -1, -2 averages to -1, not -2
    add_row(REQ_INS_BACK,  0,   -2, 1'b0);
    add_row(REQ_AVERAGE,   0,   0,  1'b0);
    add_row(REQ_CLEAR,     0,   0,  1'b1, STAT_OK, 0, 0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_table[i]) begin
      next_slot();
      offer(stim_table[i].req, stim_table[i].typed, stim_table[i].rsp);
    end
    wait_drained();

    counted    = 0;
    next_pause = PAUSE_EVERY;
    while (counted < RANDOM_ITEMS) begin
      ep      = episode_e'($urandom_range(0, 2));
      loud    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
      idle_on = ($urandom_range(0, 3) != 0);
      span    = (ep == EP_FILL) ? $urandom_range(60, 140) : $urandom_range(20, 100);
      for (int k = 0; k < span && counted < RANDOM_ITEMS; k++) begin
        calm = (counted >= RANDOM_ITEMS - CALM_ITEMS);
        next_slot();
        r = draw_request(ep, loud);
        offer(r, 1'b0, '0);
        if (r.op <= REQ_CLEAR) counted++;
        if (counted >= next_pause) begin
          wait_drained();
          next_pause += PAUSE_EVERY;
        end
      end
    end

    calm = 1'b1;
    wait_drained();
    repeat (LINGER) @(posedge clk_i);
    if (mismatches == 0 && expected_rsp.size() == 0)
      $display("shifting_array_list_engine_core_tb OK");
    else
      $display("shifting_array_list_engine_core_tb NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sal_pkg.sv
rtl/core/sal_req_if.sv
rtl/core/sal_rsp_if.sv
rtl/core/sal_div.sv
rtl/core/sal_dp.sv
rtl/core/sal_ctrl.sv
rtl/core/shifting_array_list_engine_core.sv
sim/shifting_array_list_engine_core_tb.sv
